FILE: hdl/rgvf_pkg.sv
// ----------------------------------------------------------------------------
// rgvf_pkg
// Shared types, constants and log helpers for the robust GARCH variance
// filter.
// ----------------------------------------------------------------------------
`default_nettype none

package rgvf_pkg;

  // Series length limit and fixed-point constants.
  localparam logic [20:0] MaxSeriesLen = 21'd1048576;
  localparam logic [18:0] RhoGain     = 19'd270664;
  localparam logic [47:0] RatioMax    = 48'hFFFF_FFFF_FFFF;

  // Configuration register indexes.
  localparam logic [2:0] CFG_ALPHA = 3'd0;
  localparam logic [2:0] CFG_BETA  = 3'd1;
  localparam logic [2:0] CFG_OMEGA = 3'd2;
  localparam logic [2:0] CFG_INIT  = 3'd3;
  localparam logic [2:0] CFG_CY    = 3'd4;
  localparam logic [2:0] CFG_CHISQ = 3'd5;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_SQR,
    S_DIVR,
    S_NORM1,
    S_NORM2,
    S_LOSS,
    S_DIVW,
    S_WMUL,
    S_COEF,
    S_AWR,
    S_UPD,
    S_DIVM,
    S_OUT
  } state_e;

  // Table of round(65536 * ln(1 + k/16)).
  function automatic logic [16:0] ln_tab(input logic [4:0] k);
    logic [16:0] v;
    case (k)
      5'd0:    v = 17'd0;
      5'd1:    v = 17'd3973;
      5'd2:    v = 17'd7719;
      5'd3:    v = 17'd11262;
      5'd4:    v = 17'd14624;
      5'd5:    v = 17'd17821;
      5'd6:    v = 17'd20870;
      5'd7:    v = 17'd23783;
      5'd8:    v = 17'd26573;
      5'd9:    v = 17'd29248;
      5'd10:   v = 17'd31818;
      5'd11:   v = 17'd34292;
      5'd12:   v = 17'd36675;
      5'd13:   v = 17'd38975;
      5'd14:   v = 17'd41197;
      5'd15:   v = 17'd43345;
      5'd16:   v = 17'd45426;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

  // Natural log in Q16.16 of a normalized word: x has its leading one at
  // bit 47 after lz left shifts.
  function automatic logic signed [21:0] ln_q16(input logic [47:0] x,
                                                input logic [5:0] lz);
    logic [3:0]  k;
    logic [11:0] f;
    logic [16:0] t0;
    logic [16:0] t1;
    logic [11:0] dif;
    logic [24:0] ip;
    logic [6:0]  e;
    logic [25:0] sum;
    k   = x[46:43];
    f   = x[42:31];
    t0  = ln_tab({1'b0, k});
    t1  = ln_tab({1'b0, k} + 5'd1);
    dif = 12'(t1 - t0);
    ip  = 25'(dif) * 25'(f) + 25'd2048;
    e   = 7'd31 - {1'b0, lz};
    sum = {{19{e[6]}}, e} * 26'd45426 + 26'(t0) + 26'(ip[24:12]);
    return sum[21:0];
  endfunction

endpackage

`default_nettype wire

FILE: hdl/robust_garch_variance_filter.sv
// Steps per request: the ratio division (skipped for a zero variance), the two
// bit-serial log normalizations, a weight division when the weight clips, the
// serial weight multiply, and the mean division at series end. Throughput: one
// request at a time; the next is taken in the cycle after the result is
// registered. Reset clears the sequencer, the series counter and accumulator
// and loads the register defaults.
// ----------------------------------------------------------------------------
// robust_garch_variance_filter
// GARCH(1,1) variance tracker with a bounded robust loss, using a shared
// restoring divider, serial normalizers and a serial weight multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module robust_garch_variance_filter (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [2:0]         cfg_index_i,
  input  wire logic [31:0]        cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic signed [31:0] return_sample_i,
  input  wire logic               last_in_series_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [31:0]             variance_used_o,
  output logic signed [31:0]      loss_term_o,
  output logic signed [31:0]      mean_loss_o,
  output logic                    series_done_o
);

  rgvf_pkg::state_e state_q, state_d;

  // Configuration registers.
  logic [15:0] alpha_q, beta_q;
  logic [31:0] omega_q, init_q;
  logic [19:0] cy_q;
  logic [23:0] chisq_q;

  // Series state.
  logic [31:0]        cur_q;
  logic signed [55:0] acc_q;
  logic [20:0]        cnt_q;

  // Per-request working registers.
  logic [31:0]        mag_q, h_q;
  logic               last_q;
  logic [63:0]        r2_q;
  logic [47:0]        ratio_q, rc_q, norm_q;
  logic [5:0]         ncnt_q;
  logic signed [21:0] ln1_q, ln2_q;
  logic signed [31:0] loss_q, mean_q;
  logic [16:0]        w_q;
  logic [80:0]        prod_q, mcand_q;
  logic [4:0]         wcnt_q;
  logic [32:0]        wr2_q;
  logic [20:0]        ac_q;
  logic [31:0]        bh_q;
  logic [38:0]        awr_q;
  logic               neg_q;

  // Shared divider.
  logic [63:0] dvd_q;
  logic [47:0] dvs_q, rem_q;
  logic [5:0]  step_q;

  // Output register.
  logic               out_valid_q;
  logic [31:0]        var_out_q;
  logic signed [31:0] loss_out_q, mean_out_q;
  logic               done_out_q;

  logic in_fire, out_free, div_last;
  assign in_fire  = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign div_last = (step_q == 6'd63);

  // Divider step: one quotient bit per cycle.
  logic [48:0] rem_sh;
  logic        ge;
  logic [47:0] rem_nx;
  logic [63:0] q_fin;
  always_comb begin
    rem_sh = {rem_q, dvd_q[63]};
    ge     = (rem_sh >= {1'b0, dvs_q});
    rem_nx = ge ? 48'(rem_sh - {1'b0, dvs_q}) : rem_sh[47:0];
    q_fin  = {dvd_q[62:0], ge};
  end

  // Datapath helpers.
  logic [31:0]        mag_in;
  logic [63:0]        sq;
  logic [47:0]        ratio_fin;
  logic [40:0]        gain_prod;
  logic [80:0]        prod_nx;
  logic [36:0]        ac_full;
  logic [48:0]        bh_full;
  logic [54:0]        awr_full;
  logic [40:0]        hsum;
  logic signed [56:0] acc_sum;
  logic signed [55:0] acc_sat;
  logic [54:0]        acc_abs;
  logic [20:0]        cnt_nx;
  logic signed [31:0] mean_fin;
  logic signed [31:0] loss_nx;
  always_comb begin
    mag_in    = return_sample_i[31] ? (~return_sample_i + 32'd1) : return_sample_i;
    sq        = 64'(mag_q) * 64'(mag_q);
    ratio_fin = (q_fin[63:48] != 16'd0) ? rgvf_pkg::RatioMax : q_fin[47:0];
    gain_prod = 41'(rgvf_pkg::RhoGain) * 41'(ln2_q[20:0]) + 41'd32768;
    loss_nx   = $signed({7'd0, gain_prod[40:16]}) - {{10{ln1_q[21]}}, ln1_q};
    prod_nx   = w_q[0] ? prod_q + mcand_q : prod_q;
    ac_full   = 37'(alpha_q) * 37'(cy_q) + 37'd32768;
    bh_full   = 49'(beta_q) * 49'(h_q) + 49'd32768;
    awr_full  = 55'(ac_q) * 55'(wr2_q) + 55'd32768;
    hsum      = 41'(omega_q) + 41'(awr_q) + 41'(bh_q);
    acc_sum   = {acc_q[55], acc_q} + {{25{loss_q[31]}}, loss_q};
    if (acc_sum > 57'sh7F_FFFF_FFFF_FFFF) begin
      acc_sat = 56'sh7F_FFFF_FFFF_FFFF;
    end else if (acc_sum < -57'sh7F_FFFF_FFFF_FFFF) begin
      acc_sat = -56'sh7F_FFFF_FFFF_FFFF;
    end else begin
      acc_sat = acc_sum[55:0];
    end
    acc_abs = acc_sat[55] ? 55'(-acc_sat) : acc_sat[54:0];
    cnt_nx  = (cnt_q < rgvf_pkg::MaxSeriesLen) ? cnt_q + 21'd1 : cnt_q;
    if (!neg_q) begin
      mean_fin = (q_fin > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(q_fin[31:0]);
    end else begin
      mean_fin = (q_fin > 64'h8000_0000) ? 32'sh8000_0000 : $signed(~q_fin[31:0] + 32'd1);
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      rgvf_pkg::S_IDLE:  if (in_fire) state_d = rgvf_pkg::S_SQR;
      rgvf_pkg::S_SQR: begin
        state_d = (h_q == 32'd0) ? rgvf_pkg::S_NORM1 : rgvf_pkg::S_DIVR;
      end
      rgvf_pkg::S_DIVR:  if (div_last) state_d = rgvf_pkg::S_NORM1;
      rgvf_pkg::S_NORM1: if (norm_q[47]) state_d = rgvf_pkg::S_NORM2;
      rgvf_pkg::S_NORM2: if (norm_q[47]) state_d = rgvf_pkg::S_LOSS;
      rgvf_pkg::S_LOSS: begin
        state_d = (ratio_q <= {24'd0, chisq_q}) ? rgvf_pkg::S_WMUL : rgvf_pkg::S_DIVW;
      end
      rgvf_pkg::S_DIVW:  if (div_last) state_d = rgvf_pkg::S_WMUL;
      rgvf_pkg::S_WMUL:  if (wcnt_q == 5'd16) state_d = rgvf_pkg::S_COEF;
      rgvf_pkg::S_COEF:  state_d = rgvf_pkg::S_AWR;
      rgvf_pkg::S_AWR:   state_d = rgvf_pkg::S_UPD;
      rgvf_pkg::S_UPD:   state_d = last_q ? rgvf_pkg::S_DIVM : rgvf_pkg::S_OUT;
      rgvf_pkg::S_DIVM:  if (div_last) state_d = rgvf_pkg::S_OUT;
      rgvf_pkg::S_OUT:   if (out_free) state_d = rgvf_pkg::S_IDLE;
      default:           state_d = rgvf_pkg::S_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    in_stall_o      = (state_q != rgvf_pkg::S_IDLE);
    cfg_ready_o     = 1'b1;
    out_valid_o     = out_valid_q;
    variance_used_o = var_out_q;
    loss_term_o     = loss_out_q;
    mean_loss_o     = mean_out_q;
    series_done_o   = done_out_q;
  end

  // Control state, configuration and series state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rgvf_pkg::S_IDLE;
      out_valid_q <= 1'b0;
      acc_q       <= '0;
      cnt_q       <= '0;
      alpha_q     <= 16'd6554;
      beta_q      <= 16'd58982;
      omega_q     <= 32'd6554;
      init_q      <= 32'd65536;
      cy_q        <= 20'd65536;
      chisq_q     <= 24'd393216;
    end else begin
      state_q <= state_d;
      if (state_q == rgvf_pkg::S_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == rgvf_pkg::S_UPD) begin
        acc_q <= last_q ? '0 : acc_sat;
        cnt_q <= last_q ? '0 : cnt_nx;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          rgvf_pkg::CFG_ALPHA: alpha_q <= cfg_data_i[15:0];
          rgvf_pkg::CFG_BETA:  beta_q  <= cfg_data_i[15:0];
          rgvf_pkg::CFG_OMEGA: omega_q <= cfg_data_i;
          rgvf_pkg::CFG_INIT:  init_q  <= cfg_data_i;
          rgvf_pkg::CFG_CY:    cy_q    <= cfg_data_i[19:0];
          rgvf_pkg::CFG_CHISQ: chisq_q <= cfg_data_i[23:0];
          default: ;
        endcase
      end
    end
  end

  // Datapath sequenced by the state.
  always_ff @(posedge clk_i) begin
    case (state_q)
      rgvf_pkg::S_IDLE: begin
        if (in_fire) begin
          mag_q  <= mag_in;
          last_q <= last_in_series_i;
          h_q    <= (cnt_q == 21'd0) ? init_q : cur_q;
        end
      end
      rgvf_pkg::S_SQR: begin
        r2_q   <= sq;
        dvd_q  <= sq;
        dvs_q  <= {16'd0, h_q};
        rem_q  <= '0;
        step_q <= '0;
        ratio_q <= rgvf_pkg::RatioMax;
        rc_q    <= rgvf_pkg::RatioMax;
        norm_q  <= rgvf_pkg::RatioMax;
        ncnt_q  <= '0;
      end
      rgvf_pkg::S_DIVR, rgvf_pkg::S_DIVW, rgvf_pkg::S_DIVM: begin
        dvd_q  <= q_fin;
        rem_q  <= rem_nx;
        step_q <= step_q + 6'd1;
        if (div_last) begin
          if (state_q == rgvf_pkg::S_DIVR) begin
            // Ratio is done; a zero ratio uses a floor of one LSB for the log.
            ratio_q <= ratio_fin;
            rc_q    <= (ratio_fin == 48'd0) ? 48'd1 : ratio_fin;
            norm_q  <= (ratio_fin == 48'd0) ? 48'd1 : ratio_fin;
            ncnt_q  <= '0;
          end else if (state_q == rgvf_pkg::S_DIVW) begin
            w_q     <= q_fin[16:0];
            prod_q  <= '0;
            mcand_q <= {17'd0, r2_q};
            wcnt_q  <= '0;
          end else begin
            mean_q <= mean_fin;
          end
        end
      end
      rgvf_pkg::S_NORM1: begin
        if (norm_q[47]) begin
          ln1_q  <= rgvf_pkg::ln_q16(norm_q, ncnt_q);
          norm_q <= 48'd65536 + {1'b0, rc_q[47:1]};
          ncnt_q <= '0;
        end else begin
          norm_q <= {norm_q[46:0], 1'b0};
          ncnt_q <= ncnt_q + 6'd1;
        end
      end
      rgvf_pkg::S_NORM2: begin
        if (norm_q[47]) begin
          ln2_q <= rgvf_pkg::ln_q16(norm_q, ncnt_q);
        end else begin
          norm_q <= {norm_q[46:0], 1'b0};
          ncnt_q <= ncnt_q + 6'd1;
        end
      end
      rgvf_pkg::S_LOSS: begin
        loss_q  <= loss_nx;
        // Unclipped weight, or start the weight division.
        w_q     <= 17'h10000;
        prod_q  <= '0;
        mcand_q <= {17'd0, r2_q};
        wcnt_q  <= '0;
        dvd_q   <= {24'd0, chisq_q, 16'd0};
        dvs_q   <= ratio_q;
        rem_q   <= '0;
        step_q  <= '0;
      end
      rgvf_pkg::S_WMUL: begin
        prod_q  <= prod_nx;
        mcand_q <= {mcand_q[79:0], 1'b0};
        w_q     <= {1'b0, w_q[16:1]};
        wcnt_q  <= wcnt_q + 5'd1;
        if (wcnt_q == 5'd16) begin
          wr2_q <= (prod_nx[80:32] > 49'h1_0000_0000) ? 33'h1_0000_0000 : prod_nx[64:32];
        end
      end
      rgvf_pkg::S_COEF: begin
        ac_q <= ac_full[36:16];
        bh_q <= bh_full[47:16];
      end
      rgvf_pkg::S_AWR: begin
        awr_q <= awr_full[54:16];
      end
      rgvf_pkg::S_UPD: begin
        cur_q  <= (hsum > 41'hFFFF_FFFF) ? 32'hFFFF_FFFF : hsum[31:0];
        mean_q <= '0;
        // Mean of the series: magnitude divide, sign restored at the end.
        neg_q  <= acc_sat[55];
        dvd_q  <= {9'd0, acc_abs};
        dvs_q  <= {27'd0, cnt_nx};
        rem_q  <= '0;
        step_q <= '0;
      end
      rgvf_pkg::S_OUT: begin
        if (out_free) begin
          var_out_q  <= h_q;
          loss_out_q <= loss_q;
          mean_out_q <= mean_q;
          done_out_q <= last_q;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

FILE: hdl/rgvf_checker.sv
// ----------------------------------------------------------------------------
// rgvf_checker
// Port-level checks of the robust GARCH variance filter, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module rgvf_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               cfg_valid_i,
  input wire logic               cfg_ready_o,
  input wire logic [2:0]         cfg_index_i,
  input wire logic [31:0]        cfg_data_i,
  input wire logic               in_valid_i,
  input wire logic               in_stall_o,
  input wire logic signed [31:0] return_sample_i,
  input wire logic               last_in_series_i,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire logic [31:0]        variance_used_o,
  input wire logic signed [31:0] loss_term_o,
  input wire logic signed [31:0] mean_loss_o,
  input wire logic               series_done_o
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(variance_used_o) && $stable(loss_term_o)
      && $stable(mean_loss_o) && $stable(series_done_o))
    else $error("stalled result changed");

  // Only one request is worked on at a time.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request taken while busy");

  // The mean is reported only when the series closes.
  a_mean_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !series_done_o |-> mean_loss_o == 32'sd0)
    else $error("mean shown outside series end");

endmodule

bind robust_garch_variance_filter rgvf_checker u_rgvf_checker (.*);

`default_nettype wire
